FILE: design/rrl_pkg.sv
// Package for the response rate limiter.
// Holds the transaction structs, the table entry layout, register indexes and helper functions.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package rrl_pkg;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned TotalW    = 64;
  localparam int unsigned FoldShift = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WindowW  = 16;
  localparam int unsigned MaxRespW = 16;
  localparam int unsigned SlipW    = 8;

  localparam logic [CfgIdxW-1:0] CfgWindowSeconds = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxResponses  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSlipRate      = 2'd2;

  localparam logic [WindowW-1:0]  WindowReset  = 16'd1;
  localparam logic [MaxRespW-1:0] MaxRespReset = 16'd5;
  localparam logic [SlipW-1:0]    SlipReset    = 8'd2;

  typedef enum logic [1:0] {
    ActAllow    = 2'd0,
    ActDrop     = 2'd1,
    ActTruncate = 2'd2
  } action_e;

  typedef struct packed {
    logic [AddrW-1:0] client_address;
    logic [TimeW-1:0] now_seconds;
  } in_t;

  typedef struct packed {
    action_e           action;
    logic [TotalW-1:0] allowed_total;
    logic [TotalW-1:0] dropped_total;
    logic [TotalW-1:0] truncated_total;
  } out_t;

  typedef struct packed {
    logic [AddrW-1:0]  address;
    logic [TimeW-1:0]  win_base;
    logic [CountW-1:0] resp_cnt;
    logic [CountW-1:0] drop_cnt;
  } entry_t;

  function automatic logic [AddrW-1:0] fold(input logic [AddrW-1:0] addr);
    return addr ^ (addr >> FoldShift);
  endfunction

  function automatic logic [CountW-1:0] sat_inc32(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + CountW'(1);
  endfunction

  function automatic logic [TotalW-1:0] sat_inc64(input logic [TotalW-1:0] v);
    return (v == '1) ? v : v + TotalW'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/rrl_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the client table of the response rate limiter; no dependencies.
`default_nettype none

module rrl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/rrl_rem.sv
// Iterative remainder unit: restoring division, several dividend bits per cycle.
// Used for the slip check against the configured slip rate; depends on no package.
`default_nettype none

module rrl_rem #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 17,
  parameter int unsigned STEP_BITS  = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned Steps = DIVIDEND_W / STEP_BITS;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [DIVISOR_W:0]    rem_q;
  logic [DIVISOR_W:0]    rem_d;
  logic [DIVIDEND_W-1:0] shift_q;
  logic [DIVIDEND_W-1:0] shift_d;
  logic [DIVISOR_W-1:0]  div_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic                  done_q;

  always_comb begin
    rem_d   = rem_q;
    shift_d = shift_q;
    for (int k = 0; k < STEP_BITS; k++) begin
      rem_d   = {rem_d[DIVISOR_W-1:0], shift_d[DIVIDEND_W-1]};
      shift_d = {shift_d[DIVIDEND_W-2:0], 1'b0};
      if (rem_d >= {1'b0, div_q}) begin
        rem_d = rem_d - {1'b0, div_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(Steps);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      shift_q <= dividend_i;
      div_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      shift_q <= shift_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DIVISOR_W-1:0];

endmodule

`default_nettype wire

FILE: design/response_rate_limiter.sv
// Top level of the response rate limiter: control sequencer, totals and configuration.
// Depends on rrl_pkg, rrl_ram (client table) and rrl_rem (remainder unit).
`default_nettype none

// Each input transaction (client address, time in seconds) yields exactly one output
// transaction with the decision (allow, drop or truncate) and the three running totals.
// Clients share a direct-mapped table held in one synchronous RAM; each transaction does a
// single read-modify-write of its table entry, so transactions are handled one at a time.
// After reset the table is cleared one entry per cycle, during which no input is accepted;
// configuration writes are taken at any time. A transaction passes the slot, evaluate,
// decide and write steps on its way to the result register, and the next one is accepted
// once the block is idle again. A table size that is not a power of two lengthens the slot
// step for the slot reduction by reciprocal multiplication, and a request beyond the response
// limit with a nonzero slip rate adds a slip step for the slip remainder, computed 4 bits per
// cycle. The last step waits while an earlier result is still held in the output register.
// A new transaction is accepted while an earlier result still waits in the output register.
module response_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rrl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rrl_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rrl_pkg::out_t                      out_data_o
);

  localparam int unsigned IdxW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned SlotDivW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RemW     = SlotDivW + 1;
  localparam int unsigned ProdW    = 2 * rrl_pkg::AddrW;
  localparam bit          Pow2     = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam int unsigned EntryW   = $bits(rrl_pkg::entry_t);
  localparam logic [rrl_pkg::AddrW-1:0] Recip =
    rrl_pkg::AddrW'((64'd1 << rrl_pkg::AddrW) / TABLE_ENTRIES);
  localparam logic [RemW-1:0] SlotMod = RemW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_EVAL,
    S_DECIDE,
    S_SLIP,
    S_WRITE
  } state_e;

  state_e                          state_q;
  logic [IdxW-1:0]                 clr_idx_q;
  logic [1:0]                      slot_step_q;
  logic [rrl_pkg::WindowW-1:0]     window_q;
  logic [rrl_pkg::MaxRespW-1:0]    max_q;
  logic [rrl_pkg::SlipW-1:0]       slip_q;
  logic [rrl_pkg::TotalW-1:0]      allowed_q;
  logic [rrl_pkg::TotalW-1:0]      dropped_q;
  logic [rrl_pkg::TotalW-1:0]      truncated_q;
  logic [rrl_pkg::TotalW-1:0]      allowed_d;
  logic [rrl_pkg::TotalW-1:0]      dropped_d;
  logic [rrl_pkg::TotalW-1:0]      truncated_d;
  logic                            out_valid_q;
  rrl_pkg::out_t                   out_q;

  rrl_pkg::in_t                    in_q;
  logic [ProdW-1:0]                recip_prod_q;
  logic [RemW-1:0]                 slot_rem_q;
  logic [IdxW-1:0]                 slot_q;
  logic                            miss_q;
  logic [rrl_pkg::CountW-1:0]      resp_q;
  logic [rrl_pkg::CountW-1:0]      drop_q;
  logic [rrl_pkg::TimeW-1:0]       start_q;
  rrl_pkg::entry_t                 wb_q;
  rrl_pkg::action_e                action_q;

  logic                            in_accept;
  logic                            commit;
  logic                            ram_we;
  logic                            ram_re;
  logic [IdxW-1:0]                 ram_waddr;
  logic [IdxW-1:0]                 slot_pick;
  logic [IdxW-1:0]                 slot_red;
  logic [EntryW-1:0]               ram_wdata;
  logic [EntryW-1:0]               ram_rdata;
  rrl_pkg::entry_t                 rd;
  logic [rrl_pkg::AddrW-1:0]       slot_fold;
  logic [rrl_pkg::TimeW-1:0]       age;
  logic                            over_limit;
  logic                            slip_start;
  logic [rrl_pkg::CountW-1:0]      div_dividend;
  logic                            div_done;
  logic [rrl_pkg::SlipW-1:0]       div_rem;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);

  assign slot_fold = rrl_pkg::fold(in_q.client_address);
  assign slot_red  = (slot_rem_q >= SlotMod) ? IdxW'(slot_rem_q - SlotMod) : IdxW'(slot_rem_q);
  assign slot_pick = Pow2 ? slot_fold[IdxW-1:0] : slot_red;
  assign ram_re    = (state_q == S_SLOT) && (Pow2 || (slot_step_q == 2'd2));
  assign ram_we    = (state_q == S_CLEAR) || commit;
  assign ram_waddr = (state_q == S_CLEAR) ? clr_idx_q : slot_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : wb_q;
  assign rd        = rrl_pkg::entry_t'(ram_rdata);

  assign age        = in_q.now_seconds - rd.win_base;
  assign over_limit = resp_q > {{(rrl_pkg::CountW - rrl_pkg::MaxRespW){1'b0}}, max_q};
  assign slip_start = (state_q == S_DECIDE) && !miss_q && over_limit && (slip_q != '0);

  assign div_dividend = rrl_pkg::sat_inc32(drop_q);

  assign allowed_d   = (action_q == rrl_pkg::ActAllow) ? rrl_pkg::sat_inc64(allowed_q)
                                                       : allowed_q;
  assign dropped_d   = (action_q == rrl_pkg::ActDrop) ? rrl_pkg::sat_inc64(dropped_q)
                                                      : dropped_q;
  assign truncated_d = (action_q == rrl_pkg::ActTruncate) ? rrl_pkg::sat_inc64(truncated_q)
                                                          : truncated_q;

  rrl_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(slot_pick),
    .rdata_o(ram_rdata)
  );

  rrl_rem #(
    .DIVIDEND_W(rrl_pkg::CountW),
    .DIVISOR_W (rrl_pkg::SlipW),
    .STEP_BITS (4)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (slip_start),
    .dividend_i(div_dividend),
    .divisor_i (slip_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      slot_step_q <= '0;
      window_q    <= rrl_pkg::WindowReset;
      max_q       <= rrl_pkg::MaxRespReset;
      slip_q      <= rrl_pkg::SlipReset;
      allowed_q   <= '0;
      dropped_q   <= '0;
      truncated_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rrl_pkg::CfgWindowSeconds: window_q <= cfg_wdata_i[rrl_pkg::WindowW-1:0];
          rrl_pkg::CfgMaxResponses:  max_q    <= cfg_wdata_i[rrl_pkg::MaxRespW-1:0];
          rrl_pkg::CfgSlipRate:      slip_q   <= cfg_wdata_i[rrl_pkg::SlipW-1:0];
          default: ;
        endcase
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + IdxW'(1);
          if (clr_idx_q == IdxW'(TABLE_ENTRIES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            state_q     <= S_SLOT;
            slot_step_q <= '0;
          end
        end
        S_SLOT: begin
          if (ram_re) begin
            state_q <= S_EVAL;
          end else begin
            slot_step_q <= slot_step_q + 2'd1;
          end
        end
        S_EVAL: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          state_q <= slip_start ? S_SLIP : S_WRITE;
        end
        S_SLIP: begin
          if (div_done) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (commit) begin
            allowed_q   <= allowed_d;
            dropped_q   <= dropped_d;
            truncated_q <= truncated_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (state_q == S_SLOT) begin
      recip_prod_q <= ProdW'(slot_fold) * ProdW'(Recip);
      slot_rem_q   <= RemW'(slot_fold) -
                      RemW'(recip_prod_q[ProdW-1:rrl_pkg::AddrW]) * SlotMod;
    end
    if (ram_re) begin
      slot_q <= slot_pick;
    end
    if (state_q == S_EVAL) begin
      miss_q  <= (rd.address != in_q.client_address) ||
                 (age >= {{(rrl_pkg::TimeW - rrl_pkg::WindowW){1'b0}}, window_q});
      resp_q  <= rrl_pkg::sat_inc32(rd.resp_cnt);
      drop_q  <= rd.drop_cnt;
      start_q <= rd.win_base;
    end
    if (state_q == S_DECIDE) begin
      wb_q.address <= in_q.client_address;
      if (miss_q) begin
        wb_q.win_base <= in_q.now_seconds;
        wb_q.resp_cnt <= rrl_pkg::CountW'(1);
        wb_q.drop_cnt <= '0;
        action_q      <= rrl_pkg::ActAllow;
      end else if (!over_limit) begin
        wb_q.win_base <= start_q;
        wb_q.resp_cnt <= resp_q;
        wb_q.drop_cnt <= '0;
        action_q      <= rrl_pkg::ActAllow;
      end else begin
        wb_q.win_base <= start_q;
        wb_q.resp_cnt <= resp_q;
        wb_q.drop_cnt <= rrl_pkg::sat_inc32(drop_q);
        action_q      <= rrl_pkg::ActDrop;
      end
    end
    if ((state_q == S_SLIP) && div_done) begin
      action_q <= (div_rem == '0) ? rrl_pkg::ActTruncate : rrl_pkg::ActDrop;
    end
    if (commit) begin
      out_q.action          <= action_q;
      out_q.allowed_total   <= allowed_d;
      out_q.dropped_total   <= dropped_d;
      out_q.truncated_total <= truncated_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && (out_q.action == $past(action_q)))
    else $error("result register not loaded on commit");

  a_truncate_needs_slip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (action_q == rrl_pkg::ActTruncate)) |-> (slip_q != '0))
    else $error("truncate with slip rate zero");

  a_totals_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(allowed_q) && $stable(dropped_q) && $stable(truncated_q))
    else $error("totals changed without a commit");

endmodule

`default_nettype wire

FILE: verif/tb_response_rate_limiter.sv
// Self-checking testbench for response_rate_limiter: directed and random client queries,
// with random gaps and stalls on both channels, checked against an in-bench decision model.
// Depends on rrl_pkg and the response_rate_limiter RTL.
`default_nettype none

module tb_response_rate_limiter;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned SlotW        = $clog2(TableEntries);
  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned PhaseQueries = 150;
  localparam int unsigned HoldAt       = 400;
  localparam int unsigned HoldCycles   = 300;
  localparam longint unsigned LimitCycles = 1_000_000;
  localparam logic [rrl_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [rrl_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [rrl_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  rrl_pkg::in_t                 in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  rrl_pkg::out_t                out_data_o;

  response_rate_limiter #(
    .TABLE_ENTRIES(TableEntries)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  logic [rrl_pkg::AddrW-1:0]    slot_owner     [TableEntries];
  logic [rrl_pkg::TimeW-1:0]    slot_start     [TableEntries];
  logic [rrl_pkg::CountW-1:0]   slot_responses [TableEntries];
  logic [rrl_pkg::CountW-1:0]   slot_drops     [TableEntries];
  logic [rrl_pkg::TotalW-1:0]   allowed_sum;
  logic [rrl_pkg::TotalW-1:0]   dropped_sum;
  logic [rrl_pkg::TotalW-1:0]   truncated_sum;
  logic [rrl_pkg::WindowW-1:0]  window_len;
  logic [rrl_pkg::MaxRespW-1:0] response_limit;
  logic [rrl_pkg::SlipW-1:0]    slip_every;

  rrl_pkg::in_t  queries_to_send[$];
  rrl_pkg::out_t expected_decisions[$];
  int unsigned mismatch_count = 0;
  bit sender_no_gaps = 1'b0;
  bit receiver_no_stalls = 1'b0;

  function automatic logic [rrl_pkg::TotalW-1:0] bump_total(
    input logic [rrl_pkg::TotalW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic rrl_pkg::out_t rate_decide(input rrl_pkg::in_t q);
    logic [rrl_pkg::AddrW-1:0] folded;
    logic [rrl_pkg::TimeW-1:0] age;
    logic [SlotW-1:0] slot;
    rrl_pkg::out_t res;
    folded = q.client_address ^ (q.client_address >> rrl_pkg::FoldShift);
    slot = SlotW'(folded % TableEntries);
    age = q.now_seconds - slot_start[slot];
    if (slot_owner[slot] != q.client_address || age >= 32'(window_len)) begin
      slot_owner[slot] = q.client_address;
      slot_start[slot] = q.now_seconds;
      slot_responses[slot] = 1;
      slot_drops[slot] = 0;
      allowed_sum = bump_total(allowed_sum);
      res.action = rrl_pkg::ActAllow;
    end else begin
      if (slot_responses[slot] != '1) slot_responses[slot] = slot_responses[slot] + 1'b1;
      if (slot_responses[slot] <= 32'(response_limit)) begin
        slot_drops[slot] = 0;
        allowed_sum = bump_total(allowed_sum);
        res.action = rrl_pkg::ActAllow;
      end else begin
        if (slot_drops[slot] != '1) slot_drops[slot] = slot_drops[slot] + 1'b1;
        if (slip_every != 0 && slot_drops[slot] % 32'(slip_every) == 0) begin
          truncated_sum = bump_total(truncated_sum);
          res.action = rrl_pkg::ActTruncate;
        end else begin
          dropped_sum = bump_total(dropped_sum);
          res.action = rrl_pkg::ActDrop;
        end
      end
    end
    res.allowed_total = allowed_sum;
    res.dropped_total = dropped_sum;
    res.truncated_total = truncated_sum;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_decisions.push_back(rate_decide(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (queries_to_send.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= queries_to_send.pop_front();
          gap_left <= sender_no_gaps ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned results_seen;
  bit hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    rrl_pkg::out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      results_seen = 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_decisions.size() == 0) begin
          $error("unexpected transaction: action %0d", out_data_o.action);
          mismatch_count++;
        end else begin
          want = expected_decisions.pop_front();
          if (out_data_o.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, out_data_o.action);
            mismatch_count++;
          end
          if (out_data_o.allowed_total !== want.allowed_total) begin
            $error("allowed_total: expected %0d, actual %0d",
                   want.allowed_total, out_data_o.allowed_total);
            mismatch_count++;
          end
          if (out_data_o.dropped_total !== want.dropped_total) begin
            $error("dropped_total: expected %0d, actual %0d",
                   want.dropped_total, out_data_o.dropped_total);
            mismatch_count++;
          end
          if (out_data_o.truncated_total !== want.truncated_total) begin
            $error("truncated_total: expected %0d, actual %0d",
                   want.truncated_total, out_data_o.truncated_total);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (results_seen == HoldAt && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left <= receiver_no_stalls ? 0 : pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [rrl_pkg::CfgIdxW-1:0] idx,
                           input logic [rrl_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    unique case (idx)
      rrl_pkg::CfgWindowSeconds: window_len = value;
      rrl_pkg::CfgMaxResponses: response_limit = value;
      rrl_pkg::CfgSlipRate: slip_every = value[rrl_pkg::SlipW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (queries_to_send.size() != 0 || in_valid_i || expected_decisions.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Most traffic is bursts from a few clients, some of them sharing a table slot.
  task automatic queue_traffic(input int unsigned count);
    logic [rrl_pkg::AddrW-1:0] pool [6];
    logic [rrl_pkg::TimeW-1:0] clock_now;
    logic [rrl_pkg::AddrW-1:0] who;
    int unsigned made;
    int unsigned burst;
    pool[0] = $urandom;
    pool[1] = pool[0] ^ 32'h0001_0001;
    pool[2] = $urandom;
    pool[3] = pool[2] ^ 32'h0003_0003;
    pool[4] = $urandom;
    pool[5] = $urandom_range(0, 1) ? 32'h0 : $urandom;
    clock_now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 40);
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queries_to_send.push_back('{client_address: $urandom, now_seconds: $urandom});
        made++;
      end else begin
        who = pool[$urandom_range(0, 5)];
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          queries_to_send.push_back('{client_address: who, now_seconds: clock_now});
          made++;
          case ($urandom_range(0, 7))
            0: clock_now += $urandom_range(1, 32'(window_len) + 1);
            1: clock_now += $urandom_range(0, 2);
            default: ;
          endcase
        end
        if ($urandom_range(0, 15) == 0) clock_now += $urandom;
      end
    end
  endtask

  logic [rrl_pkg::WindowW-1:0]  win_list  [8] = '{16'd3, 16'd0, 16'd10, 16'd65535,
                                                  16'd1, 16'd65535, 16'd1, 16'd5};
  logic [rrl_pkg::MaxRespW-1:0] max_list  [8] = '{16'd4, 16'd2, 16'd0, 16'd3,
                                                  16'd1, 16'd65535, 16'd1, 16'd2};
  logic [rrl_pkg::SlipW-1:0]    slip_list [8] = '{8'd3, 8'd2, 8'd1, 8'd0,
                                                  8'd255, 8'd255, 8'd1, 8'd4};

  initial begin
    logic [rrl_pkg::WindowW-1:0]  w;
    logic [rrl_pkg::MaxRespW-1:0] m;
    logic [rrl_pkg::SlipW-1:0]    s;
    foreach (slot_owner[k]) begin
      slot_owner[k] = '0;
      slot_start[k] = '0;
      slot_responses[k] = '0;
      slot_drops[k] = '0;
    end
    allowed_sum = '0;
    dropped_sum = '0;
    truncated_sum = '0;
    window_len = rrl_pkg::WindowReset;
    response_limit = rrl_pkg::MaxRespReset;
    slip_every = rrl_pkg::SlipReset;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A never-used slot still holds address zero, so client zero matches it at time zero.
    queries_to_send.push_back('{client_address: 32'h0, now_seconds: 32'h0});
    queries_to_send.push_back('{client_address: 32'h0, now_seconds: 32'h0});
    repeat (8) queries_to_send.push_back('{client_address: 32'hFFFF_FFFF,
                                           now_seconds: 32'hFFFF_FFFF});
    // The time counter wraps to zero, which ends the one-second window.
    queries_to_send.push_back('{client_address: 32'hFFFF_FFFF, now_seconds: 32'h0});
    queries_to_send.push_back('{client_address: 32'h0001_0001, now_seconds: 32'h0});
    repeat (8) queries_to_send.push_back('{client_address: 32'hA5A5_5A5A,
                                           now_seconds: 32'h8000_0000});
    queries_to_send.push_back('{client_address: 32'h5A5A_A5A5, now_seconds: 32'h7FFF_FFFF});
    wait_idle();

    write_reg(CfgUnused, 16'($urandom));

    for (int p = 0; p < 8; p++) begin
      w = win_list[p];
      m = max_list[p];
      s = slip_list[p];
      if (p == 6) begin
        w = 16'($urandom_range(1, 20));
        m = 16'($urandom_range(1, 8));
        s = 8'($urandom_range(1, 6));
      end
      sender_no_gaps = (p % 3 == 1);
      receiver_no_stalls = (p % 3 == 1);
      write_reg(rrl_pkg::CfgWindowSeconds, w);
      write_reg(rrl_pkg::CfgMaxResponses, m);
      write_reg(rrl_pkg::CfgSlipRate, {8'($urandom), s});
      queue_traffic(PhaseQueries);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
